@@ rtl/pcg_pkg.sv @@
`timescale 1ns / 1ps

package pcg_pkg;

  localparam logic [63:0] LCG_MULT = 64'd6364136223846793005;
  localparam logic [31:0] MULT_LO  = LCG_MULT[31:0];
  localparam logic [31:0] MULT_HI  = LCG_MULT[63:32];
  // Dividend for the rejection threshold, 2^32.
  localparam logic [32:0] TWO_POW_32 = 33'h1_0000_0000;
  localparam logic [31:0] SPAN_FULL  = 32'hFFFF_FFFF;
  localparam logic [5:0]  DIV_STEPS  = 6'd33;

  typedef enum logic [2:0] {
    CMD_SEED     = 3'd0,
    CMD_RESTORE  = 3'd1,
    CMD_WORD     = 3'd2,
    CMD_RANGE    = 3'd3,
    CMD_FRACTION = 3'd4
  } cmd_e;

  typedef enum logic {
    CFG_SEED   = 1'b0,
    CFG_STREAM = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    RES_WORD,
    RES_RANGE_LOW,
    RES_RANGE_RAW,
    RES_RANGE_MOD,
    RES_FRACTION
  } res_sel_e;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
    logic [63:0]        restore_state;
    logic [63:0]        restore_increment;
  } item_t;

  typedef struct packed {
    logic [31:0]        word_draw;
    logic signed [31:0] range_value;
    logic [52:0]        fraction_bits;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     latch_item;
    logic     load_seed;
    logic     add_seed;
    logic     load_restore;
    logic     adv_start;
    logic     div_start;
    logic     div_limit;
    logic     cap_frac;
    logic     res_valid;
    res_sel_e res_sel;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] cmd;
    logic       range_empty;
    logic       range_full;
    logic       below_limit;
    logic       adv_done;
    logic       div_done;
  } dp_status_t;

  // XSH-RR output permutation of a 64-bit state.
  function automatic logic [31:0] mix_out(input logic [63:0] s);
    logic [63:0] xs;
    logic [31:0] x;
    logic [63:0] rot;
    xs  = (s >> 18) ^ s;
    x   = xs[58:27];
    rot = {x, x} >> s[63:59];
    return rot[31:0];
  endfunction

endpackage

@@ rtl/pcg_ctrl.sv @@
`timescale 1ns / 1ps

module pcg_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  pcg_pkg::dp_status_t status_i,
  output pcg_pkg::ctrl_cmd_t  ctrl_o,
  output logic                busy
);
  import pcg_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SEED_KICK1,
    ST_SEED_ADV1,
    ST_SEED_ADD,
    ST_SEED_KICK2,
    ST_SEED_ADV2,
    ST_WORD,
    ST_RAW,
    ST_LIMIT,
    ST_DRAW,
    ST_REDRAW,
    ST_MOD,
    ST_FRAC_A,
    ST_FRAC_KICK,
    ST_FRAC_B
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  always_comb begin
    ctrl_o  = '0;
    ctrl_o.res_sel = RES_WORD;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          ctrl_o.latch_item = 1'b1;
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (cmd_e'(status_i.cmd))
          CMD_SEED: begin
            ctrl_o.load_seed = 1'b1;
            state_d = ST_SEED_KICK1;
          end
          CMD_RESTORE: begin
            ctrl_o.load_restore = 1'b1;
            state_d = ST_IDLE;
          end
          CMD_WORD: begin
            ctrl_o.adv_start = 1'b1;
            state_d = ST_WORD;
          end
          CMD_RANGE: begin
            if (status_i.range_empty) begin
              ctrl_o.res_valid = 1'b1;
              ctrl_o.res_sel   = RES_RANGE_LOW;
              state_d = ST_IDLE;
            end else if (status_i.range_full) begin
              ctrl_o.adv_start = 1'b1;
              state_d = ST_RAW;
            end else begin
              ctrl_o.div_start = 1'b1;
              ctrl_o.div_limit = 1'b1;
              state_d = ST_LIMIT;
            end
          end
          CMD_FRACTION: begin
            ctrl_o.adv_start = 1'b1;
            state_d = ST_FRAC_A;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_SEED_KICK1: begin
        ctrl_o.adv_start = 1'b1;
        state_d = ST_SEED_ADV1;
      end
      ST_SEED_ADV1: begin
        if (status_i.adv_done) state_d = ST_SEED_ADD;
      end
      ST_SEED_ADD: begin
        ctrl_o.add_seed = 1'b1;
        state_d = ST_SEED_KICK2;
      end
      ST_SEED_KICK2: begin
        ctrl_o.adv_start = 1'b1;
        state_d = ST_SEED_ADV2;
      end
      ST_SEED_ADV2: begin
        if (status_i.adv_done) state_d = ST_IDLE;
      end
      ST_WORD: begin
        if (status_i.adv_done) begin
          ctrl_o.res_valid = 1'b1;
          ctrl_o.res_sel   = RES_WORD;
          state_d = ST_IDLE;
        end
      end
      ST_RAW: begin
        if (status_i.adv_done) begin
          ctrl_o.res_valid = 1'b1;
          ctrl_o.res_sel   = RES_RANGE_RAW;
          state_d = ST_IDLE;
        end
      end
      ST_LIMIT: begin
        if (status_i.div_done) begin
          ctrl_o.adv_start = 1'b1;
          state_d = ST_DRAW;
        end
      end
      ST_DRAW: begin
        if (status_i.adv_done) begin
          if (status_i.below_limit) begin
            state_d = ST_REDRAW;
          end else begin
            ctrl_o.div_start = 1'b1;
            state_d = ST_MOD;
          end
        end
      end
      // The next step must start from the state that the last step wrote.
      ST_REDRAW: begin
        ctrl_o.adv_start = 1'b1;
        state_d = ST_DRAW;
      end
      ST_MOD: begin
        if (status_i.div_done) begin
          ctrl_o.res_valid = 1'b1;
          ctrl_o.res_sel   = RES_RANGE_MOD;
          state_d = ST_IDLE;
        end
      end
      ST_FRAC_A: begin
        if (status_i.adv_done) begin
          ctrl_o.cap_frac = 1'b1;
          state_d = ST_FRAC_KICK;
        end
      end
      ST_FRAC_KICK: begin
        ctrl_o.adv_start = 1'b1;
        state_d = ST_FRAC_B;
      end
      ST_FRAC_B: begin
        if (status_i.adv_done) begin
          ctrl_o.res_valid = 1'b1;
          ctrl_o.res_sel   = RES_FRACTION;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != ST_IDLE);
    end
  end

  assign busy = busy_q;

endmodule

@@ rtl/pcg_dp.sv @@
`timescale 1ns / 1ps

module pcg_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pcg_pkg::item_t      item_i,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [63:0]         cfg_data_i,
  input  pcg_pkg::ctrl_cmd_t  ctrl_i,
  output pcg_pkg::dp_status_t status_o,
  output logic                result_valid_o,
  output pcg_pkg::result_t    result_o
);
  import pcg_pkg::*;

  item_t       item_q;
  logic [63:0] state_q, inc_q, seed_q;
  logic [62:0] stream_q;

  // LCG step engine: three 32x32 partial products, then the increment add.
  logic        adv_act_q;
  logic [1:0]  adv_cnt_q;
  logic [63:0] acc_q;
  logic [31:0] draw_q;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic        adv_done;

  // Restoring remainder unit, one bit per cycle.
  logic        div_act_q, div_done_q, div_lim_q;
  logic [5:0]  div_cnt_q;
  logic [32:0] dvd_q;
  logic [31:0] rem_q, limit_q;
  logic [31:0] span, count;
  logic [32:0] trial;
  logic        trial_ge;

  logic [26:0] frac_a_q;
  logic        res_valid_q;
  result_t     res_q, res_d;

  assign mul_a    = (adv_cnt_q == 2'd1) ? state_q[63:32] : state_q[31:0];
  assign mul_b    = (adv_cnt_q == 2'd2) ? MULT_HI : MULT_LO;
  assign prod     = mul_a * mul_b;
  assign adv_done = adv_act_q && (adv_cnt_q == 2'd3);

  assign span     = item_q.range_high - item_q.range_low;
  assign count    = span + 32'd1;
  assign trial    = {rem_q, dvd_q[32]};
  assign trial_ge = (trial >= {1'b0, count});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= 64'd0;
      inc_q       <= 64'd1;
      seed_q      <= 64'd0;
      stream_q    <= 63'd0;
      adv_act_q   <= 1'b0;
      adv_cnt_q   <= 2'd0;
      div_act_q   <= 1'b0;
      div_done_q  <= 1'b0;
      div_cnt_q   <= 6'd0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_SEED:   seed_q   <= cfg_data_i;
          CFG_STREAM: stream_q <= cfg_data_i[62:0];
          default: ;
        endcase
      end

      if (ctrl_i.load_seed) begin
        state_q <= 64'd0;
        inc_q   <= {stream_q, 1'b1};
      end else if (ctrl_i.add_seed) begin
        state_q <= state_q + seed_q;
      end else if (ctrl_i.load_restore) begin
        state_q <= item_q.restore_state;
        inc_q   <= {item_q.restore_increment[63:1], 1'b1};
      end else if (adv_done) begin
        state_q <= acc_q + inc_q;
      end

      if (ctrl_i.adv_start) begin
        adv_act_q <= 1'b1;
        adv_cnt_q <= 2'd1;
      end else if (adv_act_q) begin
        adv_cnt_q <= adv_cnt_q + 2'd1;
        if (adv_done) adv_act_q <= 1'b0;
      end

      div_done_q <= div_act_q && (div_cnt_q == 6'd1);
      if (ctrl_i.div_start) begin
        div_act_q <= 1'b1;
        div_cnt_q <= DIV_STEPS;
      end else if (div_act_q) begin
        div_cnt_q <= div_cnt_q - 6'd1;
        if (div_cnt_q == 6'd1) div_act_q <= 1'b0;
      end

      res_valid_q <= ctrl_i.res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch_item) item_q <= item_i;

    if (ctrl_i.adv_start) begin
      draw_q <= mix_out(state_q);
      acc_q  <= prod;
    end else if (adv_act_q && !adv_done) begin
      acc_q[63:32] <= acc_q[63:32] + prod[31:0];
    end

    if (ctrl_i.div_start) begin
      dvd_q     <= ctrl_i.div_limit ? TWO_POW_32 : {1'b0, draw_q};
      rem_q     <= 32'd0;
      div_lim_q <= ctrl_i.div_limit;
    end else if (div_act_q) begin
      dvd_q <= {dvd_q[31:0], 1'b0};
      rem_q <= trial_ge ? 32'(trial - {1'b0, count}) : trial[31:0];
    end

    if (div_done_q && div_lim_q) limit_q <= rem_q;
    if (ctrl_i.cap_frac) frac_a_q <= draw_q[31:5];
    if (ctrl_i.res_valid) res_q <= res_d;
  end

  always_comb begin
    res_d = '0;
    case (ctrl_i.res_sel)
      RES_WORD:      res_d.word_draw     = draw_q;
      RES_RANGE_LOW: res_d.range_value   = item_q.range_low;
      RES_RANGE_RAW: res_d.range_value   = $signed(draw_q);
      RES_RANGE_MOD: res_d.range_value   = item_q.range_low + $signed(rem_q);
      RES_FRACTION:  res_d.fraction_bits = {frac_a_q, draw_q[31:6]};
      default:       res_d = '0;
    endcase
  end

  assign status_o.cmd         = item_q.cmd;
  assign status_o.range_empty = (item_q.range_high <= item_q.range_low);
  assign status_o.range_full  = (span == SPAN_FULL);
  assign status_o.below_limit = (draw_q < limit_q);
  assign status_o.adv_done    = adv_done;
  assign status_o.div_done    = div_done_q;

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

@@ rtl/pcg32_random_generator.sv @@
`timescale 1ns / 1ps

// PCG-XSH-RR 64/32 random generator. An item is taken at a rising clock edge
// where start is high and busy is low; busy then stays high until the command
// has finished. Draw commands deliver exactly one result, shown on result_o
// for a single cycle while result_valid_o is high. The receiver cannot stall
// the block, so it must capture the result in that cycle. Seed, restore and
// unknown commands give no result. Each LCG step runs on one shared 32x32
// multiplier. A range draw with an empty, inverted or full-span range needs
// no division; any other range draw runs the threshold division, one step
// per draw including each rejected one, and the final modulo.
// Configuration writes go through cfg_we_i, cfg_index_i and cfg_data_i and
// must only be issued while busy is low.
module pcg32_random_generator (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  pcg_pkg::item_t    item_i,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [63:0]       cfg_data_i,
  output logic              result_valid_o,
  output pcg_pkg::result_t  result_o
);
  import pcg_pkg::*;

  ctrl_cmd_t  ctrl;
  dp_status_t status;

  // Sequencer: decodes the command and walks the step and divide phases.
  pcg_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .ctrl_o   (ctrl),
    .busy     (busy)
  );

  // Datapath: generator state, step engine, remainder unit, result register.
  pcg_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .ctrl_i         (ctrl),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

@@ rtl/pcg_checker.sv @@
`timescale 1ns / 1ps

module pcg_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input pcg_pkg::item_t   item_i,
  input logic             result_valid_o,
  input pcg_pkg::result_t result_o
);
  import pcg_pkg::*;

  // An accepted item always keeps the block busy for the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting an item");

  // Without a new item an idle block stays idle.
  a_idle_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!start && !busy) |=> !busy)
    else $error("block became busy without an item");

  // A result is only shown once the command has finished.
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while still busy");

  // One item gives at most one result, so strobes never come back to back.
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("two result strobes in a row");

  // A seed command produces no result.
  a_seed_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.cmd == CMD_SEED) |=> ##1 !result_valid_o)
    else $error("result after a seed command");

endmodule

bind pcg32_random_generator pcg_checker u_pcg_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the PCG-XSH-RR 64/32 generator. A scoreboard object
// keeps its own copy of the generator state and the two configuration
// registers. It predicts every draw when the item is accepted, and it checks
// each result strobe against the oldest prediction still waiting.
module testbench;
  import pcg_pkg::*;

  // Cycles to let pass after the last expected result before touching the
  // registers. A seed item gives no result but still keeps the block busy.
  localparam int unsigned SETTLE_CYCLES = 16;
  // Random items per configuration phase; six phases give about 1650 items.
  localparam int unsigned PHASE_ITEMS = 275;
  localparam int unsigned NUM_PHASES = 6;
  // Bound on the final drain. The slowest range draw is well under this.
  localparam int unsigned DRAIN_LIMIT = 4000;
  // Hard stop for a hung run.
  localparam longint unsigned TIMEOUT_NS = 64'd20_000_000;

  // Holds the predicted generator and the queue of results still owed.
  class pcg_scoreboard;
    logic [63:0] gen_state;
    logic [63:0] gen_incr;
    logic [63:0] seed_reg;
    logic [62:0] stream_reg;
    result_t     draws_due[$];
    int unsigned fail_count;
    int unsigned checked_count;
    int unsigned redraw_count;
    int unsigned item_count;

    function new();
      gen_state     = 64'd0;
      gen_incr      = 64'd1;
      seed_reg      = 64'd0;
      stream_reg    = 63'd0;
      fail_count    = 0;
      checked_count = 0;
      redraw_count  = 0;
      item_count    = 0;
    endfunction

    // The stream register only keeps 63 bits, so the top data bit is dropped.
    function void set_register(cfg_idx_e idx, logic [63:0] data);
      if (idx == CFG_SEED) begin
        seed_reg = data;
      end else begin
        stream_reg = data[62:0];
      end
    endfunction

    // Xorshift of the high bits, then a rotate right by the top five bits.
    function logic [31:0] xsh_rr(logic [63:0] s);
      logic [63:0] mixed;
      logic [31:0] x;
      logic [4:0]  rot;
      mixed = (s >> 18) ^ s;
      x     = mixed[58:27];
      rot   = s[63:59];
      return (x >> rot) | (x << (6'd32 - {1'b0, rot}));
    endfunction

    // One LCG step; the output comes from the state before the step.
    function logic [31:0] step_lcg();
      logic [63:0] prev;
      prev      = gen_state;
      gen_state = prev * 64'd6364136223846793005 + gen_incr;
      return xsh_rr(prev);
    endfunction

    // Exactly uniform value in [lo, hi]. Draws below 2^32 mod count are
    // thrown away, so every residue is equally likely.
    function logic [31:0] bounded_draw(logic [31:0] lo, logic [31:0] hi);
      logic [31:0] span;
      logic [31:0] count;
      logic [31:0] d;
      logic [63:0] limit;
      if ($signed(hi) <= $signed(lo)) return lo;
      span = hi - lo;
      if (span == 32'hFFFF_FFFF) return step_lcg();
      count = span + 32'd1;
      limit = 64'h1_0000_0000 % {32'd0, count};
      d = step_lcg();
      while ({32'd0, d} < limit) begin
        d = step_lcg();
        redraw_count++;
      end
      return lo + (d % count);
    endfunction

    function void note_item(item_t it);
      result_t     r;
      logic [31:0] first;
      logic [31:0] second;
      item_count++;
      r = '0;
      case (it.cmd)
        CMD_SEED: begin
          gen_state = 64'd0;
          gen_incr  = {stream_reg, 1'b1};
          void'(step_lcg());
          gen_state = gen_state + seed_reg;
          void'(step_lcg());
        end
        CMD_RESTORE: begin
          gen_state = it.restore_state;
          gen_incr  = it.restore_increment | 64'd1;
        end
        CMD_WORD: begin
          r.word_draw = step_lcg();
          draws_due.push_back(r);
        end
        CMD_RANGE: begin
          r.range_value = bounded_draw(it.range_low, it.range_high);
          draws_due.push_back(r);
        end
        CMD_FRACTION: begin
          first  = step_lcg();
          second = step_lcg();
          r.fraction_bits = {first[31:5], second[31:6]};
          draws_due.push_back(r);
        end
        default: begin
        end
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (draws_due.size() == 0) begin
        $error("result strobe with no draw outstanding");
        fail_count++;
        return;
      end
      want = draws_due.pop_front();
      checked_count++;
      if (got.word_draw !== want.word_draw) begin
        $error("word_draw: expected %h, got %h", want.word_draw, got.word_draw);
        fail_count++;
      end
      if (got.range_value !== want.range_value) begin
        $error("range_value: expected %0d, got %0d", want.range_value, got.range_value);
        fail_count++;
      end
      if (got.fraction_bits !== want.fraction_bits) begin
        $error("fraction_bits: expected %h, got %h", want.fraction_bits,
               got.fraction_bits);
        fail_count++;
      end
    endfunction

    function int unsigned pending();
      return draws_due.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  item_t       item_i;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [63:0] cfg_data_i;
  logic        result_valid_o;
  result_t     result_o;

  pcg_scoreboard sb = new();
  // When set, the sender issues items back to back with no idle cycles.
  bit          burst_mode;
  int unsigned phase_count;

  pcg32_random_generator u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The receiver cannot stall the block, so every strobe is checked at the
  // edge that closes its cycle. Values read here are the ones from before
  // the edge, since the block updates through nonblocking assignments.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o === 1'b1) begin
      sb.check_result(result_o);
    end
  end

  // An item with every field random; the fields the command does not use
  // carry noise, which the block must ignore.
  function automatic item_t noise_item(logic [2:0] cmd);
    item_t it;
    it.cmd               = cmd;
    it.range_low         = $urandom;
    it.range_high        = $urandom;
    it.restore_state     = {$urandom, $urandom};
    it.restore_increment = {$urandom, $urandom};
    return it;
  endfunction

  function automatic item_t bounds_item(logic [31:0] lo, logic [31:0] hi);
    item_t it;
    it            = noise_item(CMD_RANGE);
    it.range_low  = lo;
    it.range_high = hi;
    return it;
  endfunction

  // Range draws spread over the interesting shapes: tiny spans, wide ones
  // with heavy rejection, empty and inverted ranges, and the full span.
  function automatic item_t random_range_item();
    logic [31:0] lo;
    logic [31:0] hi;
    lo = $urandom;
    case ($urandom_range(0, 8))
      0: hi = lo + $urandom_range(0, 15);
      1: hi = lo + $urandom_range(0, 65535);
      2: hi = $urandom;
      3: hi = lo;
      4: hi = lo - $urandom_range(1, 100000);
      5: begin
        lo = 32'h8000_0000;
        hi = 32'h7FFF_FFFF;
      end
      6: begin
        // Count just above 2^31 rejects about half of all draws.
        lo = 32'h8000_0000 + $urandom_range(0, 1000);
        hi = lo + 32'h8000_0000 + $urandom_range(0, 255);
      end
      7: begin
        // Power-of-two count, so nothing is ever rejected.
        lo = $urandom_range(0, 1023) - 512;
        hi = lo + (32'd1 << $urandom_range(0, 30)) - 32'd1;
      end
      default: begin
        lo = $urandom_range(0, 1) ? 32'h8000_0001 : 32'h8000_0000;
        hi = lo + 32'hFFFF_FFFD + $urandom_range(0, 1);
      end
    endcase
    return bounds_item(lo, hi);
  endfunction

  // Present one item and hold it until the block takes it. Start stays high
  // on return so that a following item with no gap goes out back to back.
  task automatic send_item(item_t it);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    sb.note_item(it);
  endtask

  // Drop start and wait for every owed result, then for the tail of a
  // command that gives none, then for busy to fall.
  task automatic wait_idle();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Leaves the write enable high; the caller drops it after the last write.
  task automatic program_reg(cfg_idx_e idx, logic [63:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    sb.set_register(idx, data);
  endtask

  // Short directed run: extremes of the bounds, every command, the empty,
  // inverted and full-span ranges, restores with extreme values, and the
  // unknown command codes.
  task automatic directed_items();
    item_t it;
    send_item(noise_item(CMD_WORD));
    send_item(noise_item(CMD_FRACTION));
    send_item(bounds_item(32'd0, 32'd0));
    send_item(bounds_item(32'h8000_0000, 32'h8000_0000));
    send_item(bounds_item(32'h7FFF_FFFF, 32'h8000_0000));
    send_item(bounds_item(32'h8000_0000, 32'h7FFF_FFFF));
    send_item(bounds_item(32'h8000_0001, 32'h7FFF_FFFF));
    send_item(bounds_item(32'h8000_0000, 32'h7FFF_FFFE));
    send_item(bounds_item(32'h8000_0000, 32'd0));
    send_item(bounds_item(32'd0, 32'h7FFF_FFFF));
    send_item(bounds_item(32'd0, 32'd9));
    send_item(bounds_item(-32'sd5, 32'sd5));
    send_item(bounds_item(32'h7FFF_FFFE, 32'h7FFF_FFFF));
    it = noise_item(CMD_RESTORE);
    it.restore_state     = '0;
    it.restore_increment = '0;
    send_item(it);
    send_item(noise_item(CMD_WORD));
    it = noise_item(CMD_RESTORE);
    it.restore_state     = '1;
    it.restore_increment = '1;
    send_item(it);
    send_item(noise_item(CMD_WORD));
    send_item(noise_item(CMD_FRACTION));
    send_item(bounds_item(32'hFFFF_FF00, 32'h0000_00FF));
    send_item(noise_item(3'd5));
    send_item(noise_item(3'd6));
    send_item(noise_item(3'd7));
    send_item(noise_item(CMD_WORD));
    send_item(noise_item(CMD_SEED));
    send_item(noise_item(CMD_FRACTION));
  endtask

  task automatic random_items(int unsigned count);
    item_t       it;
    int unsigned sel;
    int unsigned done;
    done = 0;
    while (done < count) begin
      sel = $urandom_range(0, 99);
      if (sel < 4) begin
        it = noise_item(CMD_SEED);
      end else if (sel < 9) begin
        it = noise_item(CMD_RESTORE);
        case ($urandom_range(0, 5))
          0: it.restore_state = '0;
          1: it.restore_state = '1;
          2: it.restore_increment = '0;
          default: begin
          end
        endcase
      end else if (sel < 32) begin
        it = noise_item(CMD_WORD);
      end else if (sel < 72) begin
        it = random_range_item();
      end else if (sel < 94) begin
        it = noise_item(CMD_FRACTION);
      end else begin
        it = noise_item(3'($urandom_range(5, 7)));
      end
      send_item(it);
      done++;
      if ($urandom_range(0, 39) == 0) burst_mode = !burst_mode;
      // Now and then the sender holds off until all results are in.
      if ($urandom_range(0, 99) == 0) wait_idle();
    end
  endtask

  initial begin
    int unsigned waited;
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    item_i      <= '0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= CFG_SEED;
    cfg_data_i  <= '0;
    burst_mode  = 1'b0;
    phase_count = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Each phase reprograms both registers while the block is idle: first
    // both zero, then both all ones, then random settings.
    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      case (p)
        0: begin
          program_reg(CFG_SEED, 64'd0);
          program_reg(CFG_STREAM, 64'd0);
        end
        1: begin
          program_reg(CFG_SEED, '1);
          program_reg(CFG_STREAM, '1);
        end
        default: begin
          program_reg(CFG_SEED, {$urandom, $urandom});
          program_reg(CFG_STREAM, {$urandom, $urandom});
        end
      endcase
      cfg_we_i <= 1'b0;
      phase_count++;
      send_item(noise_item(CMD_SEED));
      if (p == 0) directed_items();
      random_items(PHASE_ITEMS);
    end

    start <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.fail_count += sb.pending();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Ran %0d items over %0d register settings; %0d results checked.",
             sb.item_count, phase_count, sb.checked_count);
    $display("Range draws needed %0d rejected draws in total.", sb.redraw_count);
    if (sb.fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timed out waiting for the block.");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
